// ----- rtl/assert_macros.svh -----
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/fp16m_pkg.sv -----
// -----------------------------------------------------------------------------
// fp16m_pkg
// Constants and types for the half-precision multiplier.
// -----------------------------------------------------------------------------
`default_nettype none
package fp16m_pkg;
  localparam int unsigned HalfW = 16;
  localparam int unsigned ExpW = 5;
  localparam int unsigned MantW = 10;
  localparam logic [6:0] Bias = 7'd15;
  localparam logic [ExpW-1:0] ExpMax = 5'h1F;
  localparam logic [MantW-1:0] MantMax = 10'h3FF;
endpackage
`default_nettype wire

// ----- rtl/fp16m_core.sv -----
// -----------------------------------------------------------------------------
// fp16m_core
// Combinational multiply, normalize, round-to-nearest-even, saturation and flush to zero.
// -----------------------------------------------------------------------------
`default_nettype none
module fp16m_core import fp16m_pkg::*; (
  input  wire logic [HalfW-1:0] a_i,
  input  wire logic [HalfW-1:0] b_i,
  output logic      [HalfW-1:0] p_o
);
  logic sign;
  logic [ExpW-1:0] ea, eb;
  logic [21:0] prod;
  logic [13:0] sig;
  logic [11:0] rnd;
  logic [6:0] expo;
  logic top, stk, inc;

  always_comb begin
    sign = a_i[15] ^ b_i[15];
    ea = a_i[14:10];
    eb = b_i[14:10];
    prod = {11'd0, 1'b1, a_i[9:0]} * {11'd0, 1'b1, b_i[9:0]};
    top = prod[21];
    if (top) begin
      stk = |prod[7:0];
      sig = {prod[21:9], prod[8] | stk};
    end else begin
      stk = |prod[6:0];
      sig = {prod[20:8], prod[7] | stk};
    end
    expo = {2'b0, ea} + {2'b0, eb} - Bias + {6'd0, top};
    inc = sig[2] & ((|sig[1:0]) | sig[3]);
    rnd = {1'b0, sig[13:3]} + {11'd0, inc};
    if (ea == '0 || eb == '0) begin
      p_o = {sign, 15'd0};
    end else if (!expo[6] && expo[5]) begin
      p_o = {sign, ExpMax, MantMax};
    end else if (expo[6] || expo == '0) begin
      p_o = {sign, 15'd0};
    end else if (rnd[11]) begin
      if (expo[4:0] == ExpMax) p_o = {sign, ExpMax, MantMax};
      else p_o = {sign, expo[4:0] + 5'd1, rnd[10:1]};
    end else begin
      p_o = {sign, expo[4:0], rnd[9:0]};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/fp16_multiply_grs_round.sv -----
// The operands are registered at the input transfer, then the product is registered.
// Throughput: one operand pair per cycle unless a full pipe waits on out_ready_i.
// Reset clears both stage valid flags; payload registers are not reset.
// -----------------------------------------------------------------------------
// fp16_multiply_grs_round
// Registered half-precision multiplier with round to nearest even.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fp16_multiply_grs_round import fp16m_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [HalfW-1:0] operand_a_i,
  input  wire logic [HalfW-1:0] operand_b_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [HalfW-1:0] product_o
);
  logic s1_q, s2_q;
  logic [HalfW-1:0] a_q, b_q, p_q, p_d;
  logic adv;

  assign adv = !s2_q || out_ready_i;
  assign in_ready_o = !s1_q || adv;
  assign out_valid_o = s2_q;
  assign product_o = p_q;

  fp16m_core u_core (.a_i(a_q), .b_i(b_q), .p_o(p_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_q <= in_valid_i;
      if (adv) s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
    end
    if (adv && s1_q) p_q <= p_d;
  end

  `ASSERT_NEXT(a_hold, s2_q && !out_ready_i, s2_q && $stable(p_q), "result lost while stalled")
  `ASSERT_CLK(a_ready, !in_ready_o |-> (s1_q && s2_q), "ready low without full pipe")
  `ASSERT_NEXT(a_move, s1_q && adv, s2_q, "stage one item dropped")
endmodule
`default_nettype wire
